// ===== rtl/str_pkg.sv =====
// package with sizes, word types and constants of the sorted replace-worst table
package str_pkg;

    // number of table entries
    localparam int unsigned DEPTH = 16;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // field widths
    localparam int unsigned KEY_W = 32;
    localparam int unsigned TAG_W = 16;
    localparam int unsigned IDX_W = 4;

    // mode codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // one stored entry
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // value of an entry never written since reset
    localparam entry_t ENTRY_RESET = '{key: 32'sh7FFF_FFFF, tag: '0};

    // input word
    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
        logic        [IDX_W-1:0] index;
    } in_word_t;

    // result word
    typedef struct packed {
        logic        [IDX_W-1:0] position;
        logic signed [KEY_W-1:0] out_key;
        logic        [TAG_W-1:0] out_tag;
    } out_word_t;

endpackage

// ===== rtl/str_ram.sv =====
// generic simple dual-port ram with registered read
module str_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sorted_table_replace_worst.sv =====
// top level: sorted key/tag table with replace-worst insert and indexed read
//
// The table holds DEPTH entries (key, tag) in ascending key order in one ram with a
// registered read. An insert word evicts the last entry, then walks toward
// the front one entry per cycle, reading entry j-1 and moving it to j while the new
// key is strictly smaller, and finally writes the new entry; it lands after any equal
// keys. An insert reads the last entry in S_EVICT, does one ram read and one write
// per S_SHIFT step, uses S_PLACE when it lands at the front, and S_DONE loads the
// result register. A read word goes through S_READ to S_DONE. One word is in work
// at a time; the result register lets the next word be accepted while a result waits.
// Entries never written since reset read as the largest positive key with a zero
// tag, tracked by a valid bit per entry, so no clearing pass is needed after reset.
module sorted_table_replace_worst (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  str_pkg::in_word_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output str_pkg::out_word_t out_data
);

    localparam int unsigned AW  = str_pkg::ADDR_W;
    localparam int unsigned WW  = AW + str_pkg::IDX_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EVICT = 6'b000100,
        S_SHIFT = 6'b001000,
        S_PLACE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  j_reg, j_next;
    logic [str_pkg::DEPTH-1:0]      valid_reg;
    logic                           rd_valid_reg;
    logic                           out_valid_reg, out_valid_next;
    str_pkg::out_word_t             out_reg, out_next;
    str_pkg::out_word_t             res_reg, res_next;
    str_pkg::entry_t                new_reg, new_next;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    str_pkg::entry_t                ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [str_pkg::ENTRY_W-1:0]    ram_rdata;
    str_pkg::entry_t                rd_entry;

    logic [WW-1:0]                  idx_wide;
    logic                           idx_in_range;
    logic [WW-1:0]                  j_wide;

    // table storage
    str_ram #(
        .WIDTH (str_pkg::ENTRY_W),
        .DEPTH (str_pkg::DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entries never written read as the reset value
    assign rd_entry = rd_valid_reg ? str_pkg::entry_t'(ram_rdata) : str_pkg::ENTRY_RESET;

    // read index mapping and range check
    assign idx_wide     = WW'(in_data.index);
    assign idx_in_range = idx_wide < WW'(str_pkg::DEPTH);
    assign j_wide       = WW'(j_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        res_next       = res_reg;
        new_next       = new_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        ram_we         = 1'b0;
        ram_waddr      = j_reg;
        ram_wdata      = new_reg;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    new_next.key = in_data.key;
                    new_next.tag = in_data.tag;
                    if (in_data.mode == str_pkg::MODE_READ)
                    begin
                        res_next.position = in_data.index;
                        res_next.out_key  = '0;
                        res_next.out_tag  = '0;
                        ram_raddr         = idx_wide[AW-1:0];
                        state_next        = idx_in_range ? S_READ : S_DONE;
                    end
                    else
                    begin
                        j_next     = AW'(str_pkg::DEPTH - 1);
                        ram_raddr  = AW'(str_pkg::DEPTH - 1);
                        state_next = S_EVICT;
                    end
                end
            end

            S_READ:
            begin
                res_next.out_key = rd_entry.key;
                res_next.out_tag = rd_entry.tag;
                state_next       = S_DONE;
            end

            // last entry is the evicted one; fetch its neighbor
            S_EVICT:
            begin
                res_next.out_key = rd_entry.key;
                res_next.out_tag = rd_entry.tag;
                ram_raddr        = j_reg - AW'(1);
                state_next       = S_SHIFT;
            end

            // rd_entry holds entry j-1
            S_SHIFT:
            begin
                ram_we = 1'b1;
                if (new_reg.key < rd_entry.key)
                begin
                    ram_wdata = rd_entry;
                    j_next    = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ram_raddr = j_reg - AW'(2);
                    end
                end
                else
                begin
                    res_next.position = j_wide[str_pkg::IDX_W-1:0];
                    state_next        = S_DONE;
                end
            end

            // new entry lands at the front
            S_PLACE:
            begin
                ram_we            = 1'b1;
                res_next.position = j_wide[str_pkg::IDX_W-1:0];
                state_next        = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        res_reg      <= res_next;
        new_reg      <= new_next;
        out_reg      <= out_next;
        rd_valid_reg <= valid_reg[ram_raddr];
    end

endmodule
